/* rtl/core/sidt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sidt_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int CNT_W           = 8;

	typedef enum logic [2:0] {
		FUNC_APPEND  = 3'd0,
		FUNC_REWRITE = 3'd1,
		FUNC_SET_SID = 3'd2,
		FUNC_SET_ROC = 3'd3,
		FUNC_LOOKUP  = 3'd4
	} sidt_func_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	// transaction token walking down the cell row
	typedef struct packed {
		logic             vld;
		logic             lookup;
		logic             wr_pol;
		logic             wr_sid;
		logic             wr_roc;
		logic [CNT_W-1:0] target;
		logic [CNT_W-1:0] limit;
		logic [31:0]      sid;
		logic [31:0]      roc;
		logic [7:0]       pol;
		logic             found;
		logic [CNT_W-1:0] r_idx;
		logic [7:0]       r_pol;
		logic [31:0]      r_roc;
	} sidt_tok_t;

endpackage
`default_nettype wire

/* rtl/core/sidt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module sidt_cell #(
	parameter int IDX = 0
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sidt_pkg::sidt_tok_t   tok_i,
	output sidt_pkg::sidt_tok_t   tok_o
);
	import sidt_pkg::*;

	logic [7:0]  pol_q;
	logic [31:0] sid_q;
	logic [31:0] roc_q;
	sidt_tok_t   tok_q;
	logic        sel;
	logic        hit_here;
	sidt_tok_t   tok_d;

	assign sel      = tok_i.vld && (tok_i.target == CNT_W'(IDX));
	assign hit_here = tok_i.vld && tok_i.lookup && !tok_i.found
		&& (CNT_W'(IDX) < tok_i.limit) && (sid_q == tok_i.sid);

	always_comb begin
		tok_d = tok_i;
		if (hit_here) begin
			tok_d.found = 1'b1;
			tok_d.r_idx = CNT_W'(IDX + 1);
			tok_d.r_pol = pol_q;
			tok_d.r_roc = roc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && tok_i.wr_pol) begin
			pol_q <= tok_i.pol;
		end
		if (sel && tok_i.wr_sid) begin
			sid_q <= tok_i.sid;
		end
		if (sel && tok_i.wr_roc) begin
			roc_q <= tok_i.roc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule
`default_nettype wire

/* rtl/core/srtp_session_id_table_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Session id table core.
// Command channel: present func, source_id, rollover_count, policy_number
// and entry_index with start high; the transaction is taken at a rising edge
// where start is high and busy is low. busy then stays high until the result
// has been shown.
// Result channel: done is high for exactly one cycle and qualifies hit,
// result_index, result_policy, result_rollover, status and entry_count.
// The receiver cannot stall; the result must be sampled in that cycle.
// Each transaction walks a row of MAX_ENTRIES cells, one cell per cycle;
// each cell holds one table entry and does its write or compare as the
// token passes. done is raised as the token leaves the last cell's register,
// and no new transaction is taken while one is still in the row.
// Lookup returns the lowest-numbered matching entry.
// Reset empties the table (entry count 0) and drops any transaction in
// flight; entry contents are not cleared and need no clearing pass.
module srtp_session_id_table_core #(
	parameter int MAX_ENTRIES = sidt_pkg::MAX_ENTRIES_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  func,
	input  wire  [31:0] source_id,
	input  wire  [31:0] rollover_count,
	input  wire  [7:0]  policy_number,
	input  wire  [7:0]  entry_index,
	output logic        done,
	output logic        hit,
	output logic [7:0]  result_index,
	output logic [7:0]  result_policy,
	output logic [31:0] result_rollover,
	output logic [1:0]  status,
	output logic [7:0]  entry_count
);
	import sidt_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [1:0]       status_q;
	logic             busy_q;
	logic             accept;
	logic             idx_ok;
	logic             full;
	sidt_func_t       fn;
	sidt_tok_t        inj;
	logic [CNT_W-1:0] count_d;
	logic [1:0]       status_d;
	sidt_tok_t        tok [0:MAX_ENTRIES];

	assign accept = start && !busy_q;
	assign fn     = sidt_func_t'(func);
	assign idx_ok = (entry_index != '0) && (entry_index <= count_q);
	assign full   = (count_q == CNT_W'(MAX_ENTRIES));

	always_comb begin
		inj        = '0;
		inj.vld    = accept;
		inj.sid    = source_id;
		inj.roc    = rollover_count;
		inj.pol    = policy_number;
		inj.limit  = count_q;
		inj.target = entry_index - CNT_W'(1);
		count_d    = count_q;
		status_d   = ST_OK;
		case (fn)
			FUNC_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					inj.target = count_q;
					inj.wr_pol = 1'b1;
					inj.wr_sid = 1'b1;
					inj.wr_roc = 1'b1;
					inj.r_idx  = count_q + CNT_W'(1);
					count_d    = count_q + CNT_W'(1);
				end
			end
			FUNC_REWRITE, FUNC_SET_SID, FUNC_SET_ROC: begin
				if (!idx_ok) begin
					status_d = ST_BAD_INDEX;
				end else begin
					inj.wr_pol = (fn == FUNC_REWRITE);
					inj.wr_sid = (fn == FUNC_REWRITE) || (fn == FUNC_SET_SID);
					inj.wr_roc = (fn == FUNC_REWRITE) || (fn == FUNC_SET_ROC);
				end
			end
			FUNC_LOOKUP: begin
				inj.lookup = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign tok[0] = inj;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		sidt_cell #(
			.IDX(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.tok_i (tok[i]),
			.tok_o (tok[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ST_OK;
			busy_q   <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_d;
				status_q <= status_d;
				busy_q   <= 1'b1;
			end else if (tok[MAX_ENTRIES].vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy            = busy_q;
	assign done            = tok[MAX_ENTRIES].vld;
	assign hit             = tok[MAX_ENTRIES].found;
	assign result_index    = tok[MAX_ENTRIES].r_idx;
	assign result_policy   = tok[MAX_ENTRIES].r_pol;
	assign result_rollover = tok[MAX_ENTRIES].r_roc;
	assign status          = status_q;
	assign entry_count     = count_q;

endmodule
`default_nettype wire

/* rtl/core/sidt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module sidt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire        hit,
	input wire [7:0]  result_index,
	input wire [7:0]  result_policy,
	input wire [31:0] result_rollover,
	input wire [1:0]  status,
	input wire [7:0]  entry_count
);
	import sidt_pkg::*;

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after taking a transaction");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result shown with no transaction in flight");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> result_index != 8'd0 && result_index <= entry_count
			&& status == ST_OK)
		else $error("lookup hit with bad index or status");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> !hit && result_index == 8'd0
			&& result_policy == 8'd0 && result_rollover == 32'd0)
		else $error("failed transaction carries result data");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> entry_count == $past(entry_count)
			|| entry_count == $past(entry_count) + 8'd1)
		else $error("entry count moved by more than one");

endmodule

bind srtp_session_id_table_core sidt_checker u_sidt_checker (.*);
`default_nettype wire
